// ----- hw/rtl/spq_pkg.sv -----
// Shared constants and types for the sorted priority queue.
`default_nettype none

package spq_pkg;

   // Default number of stored values
   localparam int SPQ_DEPTH   = 16;
   // Width of one stored value
   localparam int SPQ_VALUE_W = 32;
   // Width of the occupancy field in a result
   localparam int SPQ_OCC_W   = 5;
   // Byte-padded widths of the stream data words
   localparam int SPQ_REQ_DATA_W = 32;
   localparam int SPQ_RSP_DATA_W = 40;

   // Request command codes
   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } spq_cmd_type;

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_priority_queue_unit.sv -----
// Sorted priority queue, smallest value first, kept in a circular memory.
//
//   channel | direction | tdata                          | tuser
//   req_    | in        | [31:0] value                   | [0] command
//   rsp_    | out       | [31:0] removed_value,          | [0] was_empty,
//           |           | [36:32] occupancy, rest zero   | [1] overflow
//
// A remove steps through memory read, head advance and result hand-off.
// An insert walks down from the tail: with one read and one write port, each stored value
// greater than the new one moves up one place per cycle, then the new value is written.
// Reset clears the state, head, count and the result valid flag only; memory contents stay
// as they are, since only positions below the count are read.
// A new request is taken while a finished result still waits on rsp_tready.
`default_nettype none

module sorted_priority_queue_unit
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = SPQ_DEPTH
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire [SPQ_REQ_DATA_W-1:0]   req_tdata,   // [31:0] value
   input  wire [0:0]                  req_tuser,   // [0] command
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [SPQ_RSP_DATA_W-1:0]  rsp_tdata,   // [31:0] removed_value, [36:32] occupancy
   output logic [1:0]                 rsp_tuser    // [0] was_empty, [1] overflow
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int PAD_W = SPQ_RSP_DATA_W - SPQ_VALUE_W - SPQ_OCC_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RM_DATA,
      ST_INS_STEP,
      ST_FINISH
   } state_type;

   state_type                     state_ff, state_in;
   logic [AW-1:0]                 head_ff, head_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 pos_ff, pos_in;
   logic signed [SPQ_VALUE_W-1:0] val_ff, val_in;
   logic [SPQ_VALUE_W-1:0]        res_value_ff, res_value_in;
   logic                          res_empty_ff, res_empty_in;
   logic                          res_ovf_ff, res_ovf_in;
   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [SPQ_RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [1:0]                    rsp_user_ff, rsp_user_in;

   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic [SPQ_VALUE_W-1:0]        wr_data;
   logic [AW-1:0]                 rd_addr;
   logic [SPQ_VALUE_W-1:0]        rd_data;
   logic signed [SPQ_VALUE_W-1:0] rd_signed;
   logic                          rsp_load;
   logic [CW-1:0]                 cnt_m1;
   logic [CW-1:0]                 pos_m2;
   logic [CW+SPQ_OCC_W-1:0]       occ_ext;
   spq_cmd_type                   req_cmd;

   // Map a position in the order onto a memory address behind the head
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(off);
      if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
         sum = sum - (CW+1)'(QUEUE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   spq_ram #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ADDR_W      (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_signed = rd_data;
   assign req_cmd   = spq_cmd_type'(req_tuser[0]);
   assign cnt_m1    = count_ff - CW'(1);
   assign pos_m2    = (pos_ff >= CW'(2)) ? (pos_ff - CW'(2)) : '0;
   assign occ_ext   = {{SPQ_OCC_W{1'b0}}, count_ff};

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Sequence each request through the memory
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      res_value_in = res_value_ff;
      res_empty_in = res_empty_ff;
      res_ovf_in   = res_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = phys(head_ff, pos_ff);
      wr_data      = val_ff;
      rd_addr      = phys(head_ff, '0);
      rsp_load     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               val_in       = req_tdata[SPQ_VALUE_W-1:0];
               res_value_in = '0;
               res_empty_in = 1'b0;
               res_ovf_in   = 1'b0;
               if (req_cmd == CMD_REMOVE) begin
                  if (count_ff == '0) begin
                     res_empty_in = 1'b1;
                     state_in     = ST_FINISH;
                  end else begin
                     rd_addr  = phys(head_ff, '0);
                     state_in = ST_RM_DATA;
                  end
               end else if (count_ff == CW'(QUEUE_DEPTH)) begin
                  res_ovf_in = 1'b1;
                  state_in   = ST_FINISH;
               end else if (count_ff == '0) begin
                  // Empty queue: store straight at the head
                  wr_en    = 1'b1;
                  wr_addr  = head_ff;
                  wr_data  = req_tdata[SPQ_VALUE_W-1:0];
                  count_in = CW'(1);
                  state_in = ST_FINISH;
               end else begin
                  // Start the walk down from the tail
                  rd_addr  = phys(head_ff, cnt_m1);
                  pos_in   = count_ff;
                  state_in = ST_INS_STEP;
               end
            end
         end
         ST_RM_DATA: begin
            res_value_in = rd_data;
            head_in      = (head_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + AW'(1);
            count_in     = cnt_m1;
            state_in     = ST_FINISH;
         end
         ST_INS_STEP: begin
            wr_en = 1'b1;
            if ((pos_ff != '0) && (rd_signed > val_ff)) begin
               // Move the larger entry up one place, fetch the next one
               wr_data = rd_data;
               pos_in  = pos_ff - CW'(1);
               rd_addr = phys(head_ff, pos_m2);
            end else begin
               wr_data  = val_ff;
               count_in = count_ff + CW'(1);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result until the transfer completes
   always_comb begin
      rsp_tvalid_in = rsp_load || (rsp_tvalid_ff && !rsp_tready);
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      if (rsp_load) begin
         rsp_data_in = {{PAD_W{1'b0}}, occ_ext[SPQ_OCC_W-1:0], res_value_ff};
         rsp_user_in = {res_ovf_ff, res_empty_ff};
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      res_value_ff <= res_value_in;
      res_empty_ff <= res_empty_in;
      res_ovf_ff   <= res_ovf_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/spq_ram.sv -----
// Simple dual-port value store with a registered read port.
`default_nettype none

module spq_ram
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = SPQ_DEPTH,
   parameter int ADDR_W      = $clog2(QUEUE_DEPTH)
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [ADDR_W-1:0]        wr_addr,
   input  wire [SPQ_VALUE_W-1:0]   wr_data,
   input  wire [ADDR_W-1:0]        rd_addr,
   output logic [SPQ_VALUE_W-1:0]  rd_data
);

   logic [SPQ_VALUE_W-1:0] mem_ff [QUEUE_DEPTH];

   // Write one word per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- tb/sv/tb_sorted_priority_queue_unit.sv -----
// Self-checking testbench for the sorted priority queue unit on its request/response streams.
module tb_sorted_priority_queue_unit;
   import spq_pkg::*;

   // Fields of one response, in checking order
   typedef struct packed {
      logic [SPQ_VALUE_W-1:0] removed_value;
      logic                   was_empty;
      logic                   overflow;
      logic [SPQ_OCC_W-1:0]   occupancy;
   } rsp_fields_type;

   // One directed row: request plus an optional hand-written response
   typedef struct packed {
      spq_cmd_type            cmd;
      logic [SPQ_VALUE_W-1:0] value;
      bit                     typed;
      rsp_fields_type         want;
   } stim_row_type;

   localparam rsp_fields_type FROM_MODEL = '0;
   localparam int             DIRECTED_ROWS = 25;
   localparam int             SEGMENTS = 26;
   localparam int             SEGMENT_ITEMS = 50;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [SPQ_REQ_DATA_W-1:0] req_tdata;   // [31:0] value
   logic [0:0]                req_tuser;   // [0] command
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [SPQ_RSP_DATA_W-1:0] rsp_tdata;   // [31:0] removed_value, [36:32] occupancy
   logic [1:0]                rsp_tuser;   // [0] was_empty, [1] overflow

   // Shadow copy of the queue contents, ascending
   logic signed [SPQ_VALUE_W-1:0] shadow_queue[$];
   rsp_fields_type                pending_results[$];

   int  fail_count = 0;
   int  results_seen = 0;
   int  insert_count = 0;
   int  dropped_count = 0;
   int  remove_count = 0;
   int  empty_count = 0;
   int  peak_occupancy = 0;
   bit  quiet_phase = 1'b0;
   bit  long_hold_done = 1'b0;
   int  hold_cycles = 0;

   // Smallest first; equal values stay in arrival order
   stim_row_type directed_rows[DIRECTED_ROWS] = '{
      '{CMD_REMOVE, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0, 5'd0}},
      '{CMD_INSERT, 32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd1}},
      '{CMD_INSERT, 32'h8000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd2}},
      '{CMD_INSERT, 32'h0000_0000, 1'b0, FROM_MODEL},
      '{CMD_INSERT, 32'hFFFF_FFFF, 1'b0, FROM_MODEL},
      '{CMD_INSERT, 32'h0000_0001, 1'b0, FROM_MODEL},
      '{CMD_INSERT, 32'h0000_0005, 1'b0, FROM_MODEL},
      '{CMD_INSERT, 32'h0000_0005, 1'b0, FROM_MODEL},
      '{CMD_REMOVE, 32'hFFFF_FFFF, 1'b1, '{32'h8000_0000, 1'b0, 1'b0, 5'd6}},
      '{CMD_INSERT, 32'h0000_0005, 1'b0, FROM_MODEL},
      '{CMD_INSERT, 32'hFFFF_FFFB, 1'b0, FROM_MODEL},
      '{CMD_INSERT, 32'h7FFF_FFFF, 1'b0, FROM_MODEL},
      '{CMD_INSERT, 32'h8000_0000, 1'b0, FROM_MODEL},
      '{CMD_INSERT, 32'h0000_0003, 1'b0, FROM_MODEL},
      '{CMD_INSERT, 32'h0000_0002, 1'b0, FROM_MODEL},
      '{CMD_INSERT, 32'h0000_0005, 1'b0, FROM_MODEL},
      '{CMD_INSERT, 32'hAAAA_AAAA, 1'b0, FROM_MODEL},
      '{CMD_INSERT, 32'h5555_5555, 1'b0, FROM_MODEL},
      '{CMD_INSERT, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b0, 5'd16}},
      '{CMD_INSERT, 32'h0000_1234, 1'b1, '{32'h0000_0000, 1'b0, 1'b1, 5'd16}},
      '{CMD_INSERT, 32'h8000_0000, 1'b1, '{32'h0000_0000, 1'b0, 1'b1, 5'd16}},
      '{CMD_REMOVE, 32'h0000_0000, 1'b0, FROM_MODEL},
      '{CMD_REMOVE, 32'h0000_0000, 1'b0, FROM_MODEL},
      '{CMD_REMOVE, 32'h0000_0000, 1'b0, FROM_MODEL},
      '{CMD_REMOVE, 32'h0000_0000, 1'b0, FROM_MODEL}
   };

   sorted_priority_queue_unit #(
      .QUEUE_DEPTH(SPQ_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle length: mostly none, often short, rarely long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(3, 1);
      end else begin
         return $urandom_range(60, 15);
      end
   endfunction

   // Apply one request to the shadow queue and return the response it yields
   function automatic rsp_fields_type apply_request(input spq_cmd_type cmd,
                                                    input logic [SPQ_VALUE_W-1:0] value);
      rsp_fields_type result;
      int             pos;
      result = '0;
      if (cmd == CMD_REMOVE) begin
         remove_count++;
         if (shadow_queue.size() == 0) begin
            result.was_empty = 1'b1;
            empty_count++;
         end else begin
            result.removed_value = shadow_queue.pop_front();
         end
      end else begin
         insert_count++;
         if (shadow_queue.size() >= SPQ_DEPTH) begin
            result.overflow = 1'b1;
            dropped_count++;
         end else begin
            // Go behind every stored value less than or equal to the new one
            pos = 0;
            while (pos < shadow_queue.size() && shadow_queue[pos] <= $signed(value)) begin
               pos++;
            end
            shadow_queue.insert(pos, $signed(value));
         end
      end
      result.occupancy = SPQ_OCC_W'(shadow_queue.size());
      if (shadow_queue.size() > peak_occupancy) begin
         peak_occupancy = shadow_queue.size();
      end
      return result;
   endfunction

   // Offer one request, wait for the transfer, record the expected response
   task automatic send_request(input spq_cmd_type cmd, input logic [SPQ_VALUE_W-1:0] value,
                               input bit typed, input rsp_fields_type typed_want);
      rsp_fields_type predicted;
      int             gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      predicted = apply_request(cmd, value);
      pending_results.push_back(typed ? typed_want : predicted);
      gap = quiet_phase ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Receiver: random stalls, plus one long hold-off to back up the queue
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else if (!long_hold_done && results_seen >= 300) begin
            long_hold_done = 1'b1;
            hold_cycles = 400;
            rsp_tready <= 1'b0;
         end else if (quiet_phase) begin
            rsp_tready <= 1'b1;
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               hold_cycles = stall - 1;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // Compare each response transfer with the oldest expectation
   always @(posedge clock) begin : check_response
      rsp_fields_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("response transfer with no request outstanding");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            results_seen++;
            if (rsp_tdata[31:0] !== want.removed_value) begin
               $error("removed_value: expected %0d, got %0d",
                      $signed(want.removed_value), $signed(rsp_tdata[31:0]));
               fail_count++;
            end
            if (rsp_tuser[0] !== want.was_empty) begin
               $error("was_empty: expected %0b, got %0b", want.was_empty, rsp_tuser[0]);
               fail_count++;
            end
            if (rsp_tuser[1] !== want.overflow) begin
               $error("overflow: expected %0b, got %0b", want.overflow, rsp_tuser[1]);
               fail_count++;
            end
            if (rsp_tdata[36:32] !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_tdata[36:32]);
               fail_count++;
            end
         end
      end
   end

   // Stimulus: directed table, then random segments with varying insert bias
   initial begin
      int                     seg;
      int                     item;
      int                     insert_bias;
      int                     roll;
      logic [SPQ_VALUE_W-1:0] value;
      spq_cmd_type            cmd;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].cmd, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].want);
      end

      for (seg = 0; seg < SEGMENTS; seg++) begin
         // At the midpoint, hold off until the unit has answered everything outstanding
         if (seg == SEGMENTS / 2) begin
            req_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         quiet_phase = (seg % 5 == 2);
         case (seg % 4)
            0: insert_bias = 80;
            1: insert_bias = 20;
            2: insert_bias = 50;
            default: insert_bias = 60;
         endcase
         for (item = 0; item < SEGMENT_ITEMS; item++) begin
            cmd = ($urandom_range(99) < insert_bias) ? CMD_INSERT : CMD_REMOVE;
            roll = $urandom_range(99);
            if (roll < 50) begin
               value = $urandom;
            end else if (roll < 85) begin
               // Narrow range for many equal values
               value = $urandom_range(16) - 8;
            end else begin
               case ($urandom_range(4))
                  0: value = 32'h8000_0000;
                  1: value = 32'h7FFF_FFFF;
                  2: value = 32'h0000_0000;
                  3: value = 32'hFFFF_FFFF;
                  default: value = 32'h0000_0001;
               endcase
            end
            send_request(cmd, value, 1'b0, FROM_MODEL);
         end
      end
      quiet_phase = 1'b0;

      // Drain, then allow for the longest insert walk
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d requests: %0d inserts (%0d dropped when full), %0d removes",
               insert_count + remove_count, insert_count, dropped_count, remove_count);
      $display("removes on empty queue: %0d, peak occupancy: %0d of %0d",
               empty_count, peak_occupancy, SPQ_DEPTH);
      if (fail_count == 0) begin
         $display("sorted_priority_queue_unit verification clean");
      end else begin
         $display("sorted_priority_queue_unit verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("sorted_priority_queue_unit verification failed");
      $finish;
   end

endmodule

// ----- sorted_priority_queue_unit.f -----
hw/rtl/spq_pkg.sv
hw/rtl/spq_ram.sv
hw/rtl/sorted_priority_queue_unit.sv
tb/sv/tb_sorted_priority_queue_unit.sv
